/* rtl/spfd_pkg.sv */
// Shared constants and types for the stereo ping-pong feedback delay.
// No dependencies; every other file of the block imports this package.
package spfd_pkg;

  // Default sizing handed to the top level parameters
  localparam int MAX_DELAY_DEF   = 65536;
  localparam int SAMPLE_BITS_DEF = 24;

  // Q0.16 gain arithmetic
  localparam int Q16_SHIFT = 16;
  localparam int UNITY_Q16 = 65536;
  localparam int RND_HALF  = 32768;

  // Configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 17;

  localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_LEFT    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_RIGHT   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_GAIN = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WET_MIX       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PING_PONG     = 3'd4;

  // Register file contents
  typedef struct packed {
    logic [15:0] delay_left;
    logic [15:0] delay_right;
    logic [15:0] feedback_gain;
    logic [16:0] wet_mix;
    logic        ping_pong;
  } cfg_regs_t;

endpackage

/* rtl/spfd_if.sv */
// Channel interfaces of the stereo ping-pong feedback delay: sample input,
// mixed output and the configuration write channel. Depends on spfd_pkg.

interface spfd_in_if import spfd_pkg::*; #(
  parameter int SampleBits = SAMPLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] left_in;
  logic signed [SampleBits-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface spfd_out_if import spfd_pkg::*; #(
  parameter int SampleBits = SAMPLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] left_out;
  logic signed [SampleBits-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

interface spfd_cfg_if import spfd_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/stereo_pingpong_feedback_delay_top.sv */
// Stereo feedback delay with ping-pong crossing: top level.
// Depends on spfd_pkg, spfd_if (channel interfaces) and spfd_dline (delay memory).
//
// Each accepted beat carries one stereo pair of signed Q1.23 samples. Each beat
// returns one mixed pair in the output register. The three steps are the read,
// the multiply, and the round/saturate/write. The two delay memories are each
// read once and written once per cycle, so the block takes one pair per cycle,
// unless the output stalls, whenever each delay is zero or 3 or more. With a
// delay of 1 or 2 the newest slot it must read is still in the pipeline. The
// input then holds off until that slot is written.
// There is no clearing pass after reset: the write pointer and a wrap flag mark
// which slots have been written, and unwritten slots read as zero. The output
// register lets the next pair in while a result waits.
// Configuration writes are always ready and must only arrive while idle.
module stereo_pingpong_feedback_delay_top import spfd_pkg::*; #(
  parameter int MAX_DELAY   = MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  spfd_in_if.sink   samples,
  spfd_out_if.source mixed,
  spfd_cfg_if.sink  cfg
);

  localparam int S  = SAMPLE_BITS;
  localparam int AW = $clog2(MAX_DELAY);
  localparam int CW = (AW > 16) ? AW : 16;
  localparam int PW = S + 18;

  localparam logic signed [PW-1:0] SMAX = {{(PW-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN = {{(PW-S+1){1'b1}}, {(S-1){1'b0}}};

  // divide by 2^16, round to nearest, ties away from zero
  function automatic logic signed [PW-1:0] rnd_q16(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] half;
    half = v[PW-1] ? PW'(RND_HALF - 1) : PW'(RND_HALF);
    return (v + half) >>> Q16_SHIFT;
  endfunction

  function automatic logic signed [S-1:0] sat_smp(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] c;
    c = (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
    return c[S-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  cfg_regs_t regs;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.delay_left    <= 16'd1;
      regs.delay_right   <= 16'd1;
      regs.feedback_gain <= 16'd0;
      regs.wet_mix       <= 17'd0;
      regs.ping_pong     <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DELAY_LEFT:    regs.delay_left    <= cfg.data[15:0];
        REG_DELAY_RIGHT:   regs.delay_right   <= cfg.data[15:0];
        REG_FEEDBACK_GAIN: regs.feedback_gain <= cfg.data[15:0];
        REG_WET_MIX:       regs.wet_mix       <= cfg.data[16:0];
        REG_PING_PONG:     regs.ping_pong     <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- pipeline state
  logic [AW-1:0] wptr;
  logic          wrapped;

  logic                 s1_valid;
  logic signed [S-1:0]  s1_in_l, s1_in_r;
  logic [AW-1:0]        s1_waddr;
  logic                 s1_zero_l, s1_zero_r;

  logic                 s2_valid;
  logic signed [S-1:0]  s2_in_l, s2_in_r;
  logic [AW-1:0]        s2_waddr;
  logic signed [PW-1:0] s2_fb_l, s2_fb_r;
  logic signed [PW-1:0] s2_dry_l, s2_dry_r;
  logic signed [PW-1:0] s2_wet_l, s2_wet_r;

  logic                 out_valid;
  logic signed [S-1:0]  left_out, right_out;

  // ---------------------------------------------------------- read addresses
  logic [CW-1:0] dmax, dl_ext, dr_ext, dl_sat, dr_sat;
  logic [AW-1:0] dl_a, dr_a, raddr_l, raddr_r;
  logic [AW:0]   wrap_l, wrap_r;

  always_comb begin
    dmax   = CW'(MAX_DELAY - 1);
    dl_ext = CW'(regs.delay_left);
    dr_ext = CW'(regs.delay_right);
    dl_sat = (dl_ext > dmax) ? dmax : dl_ext;
    dr_sat = (dr_ext > dmax) ? dmax : dr_ext;
    dl_a   = dl_sat[AW-1:0];
    dr_a   = dr_sat[AW-1:0];
    wrap_l = {1'b0, wptr} + (AW+1)'(MAX_DELAY) - {1'b0, dl_a};
    wrap_r = {1'b0, wptr} + (AW+1)'(MAX_DELAY) - {1'b0, dr_a};
    raddr_l = (wptr >= dl_a) ? (wptr - dl_a) : wrap_l[AW-1:0];
    raddr_r = (wptr >= dr_a) ? (wptr - dr_a) : wrap_r[AW-1:0];
  end

  // ------------------------------------------------------------ flow control
  logic s3_free, s2_move, s2_free, s1_move, s1_free, hazard, accept;

  always_comb begin
    s3_free = !out_valid || mixed.ready;
    s2_move = s2_valid && s3_free;
    s2_free = !s2_valid || s2_move;
    s1_move = s1_valid && s2_free;
    s1_free = !s1_valid || s1_move;
    // slots not yet written back by beats in flight must not be read
    hazard = (s1_valid && (raddr_l == s1_waddr || raddr_r == s1_waddr)) ||
             (s2_valid && (raddr_l == s2_waddr || raddr_r == s2_waddr));
  end

  assign samples.ready = s1_free && !hazard;
  assign accept        = samples.valid && samples.ready;

  // ---------------------------------------------------------- write pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr    <= '0;
      wrapped <= 1'b0;
    end else if (accept) begin
      if (wptr == AW'(MAX_DELAY - 1)) begin
        wptr    <= '0;
        wrapped <= 1'b1;
      end else begin
        wptr <= wptr + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------- delay memories
  logic [S-1:0] q_l, q_r;
  logic [S-1:0] wdata_l, wdata_r;

  spfd_dline #(.DEPTH(MAX_DELAY), .WIDTH(S)) u_line_l (
    .clk   (clk),
    .we    (s2_move),
    .waddr (s2_waddr),
    .wdata (wdata_l),
    .re    (accept),
    .raddr (raddr_l),
    .q     (q_l)
  );

  spfd_dline #(.DEPTH(MAX_DELAY), .WIDTH(S)) u_line_r (
    .clk   (clk),
    .we    (s2_move),
    .waddr (s2_waddr),
    .wdata (wdata_r),
    .re    (accept),
    .raddr (raddr_r),
    .q     (q_r)
  );

  // ------------------------------------------------- stage 1: read issued
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_in_l   <= samples.left_in;
      s1_in_r   <= samples.right_in;
      s1_waddr  <= wptr;
      // slot never written since reset reads as zero
      s1_zero_l <= !(wrapped || raddr_l < wptr);
      s1_zero_r <= !(wrapped || raddr_r < wptr);
    end
  end

  // ---------------------------------------- stage 1 -> 2: gain products
  logic signed [S-1:0]  dl, dr, src_l, src_r;
  logic [16:0]          wet_sat, dry;
  logic signed [PW-1:0] gain_x, wet_x, dry_x;

  always_comb begin
    dl      = s1_zero_l ? '0 : signed'(q_l);
    dr      = s1_zero_r ? '0 : signed'(q_r);
    src_l   = regs.ping_pong ? dr : dl;
    src_r   = regs.ping_pong ? dl : dr;
    wet_sat = (regs.wet_mix > 17'(UNITY_Q16)) ? 17'(UNITY_Q16) : regs.wet_mix;
    dry     = 17'(UNITY_Q16) - wet_sat;
    gain_x  = signed'(PW'(regs.feedback_gain));
    wet_x   = signed'(PW'(wet_sat));
    dry_x   = signed'(PW'(dry));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_move;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_in_l  <= s1_in_l;
      s2_in_r  <= s1_in_r;
      s2_waddr <= s1_waddr;
      s2_fb_l  <= PW'(src_l) * gain_x;
      s2_fb_r  <= PW'(src_r) * gain_x;
      s2_dry_l <= PW'(s1_in_l) * dry_x;
      s2_dry_r <= PW'(s1_in_r) * dry_x;
      s2_wet_l <= PW'(dl) * wet_x;
      s2_wet_r <= PW'(dr) * wet_x;
    end
  end

  // -------------------------------- stage 2: round, saturate, write back
  logic signed [S-1:0] mix_l, mix_r;

  always_comb begin
    wdata_l = sat_smp(PW'(s2_in_l) + rnd_q16(s2_fb_l));
    wdata_r = sat_smp(PW'(s2_in_r) + rnd_q16(s2_fb_r));
    mix_l   = sat_smp(rnd_q16(s2_dry_l + s2_wet_l));
    mix_r   = sat_smp(rnd_q16(s2_dry_r + s2_wet_r));
  end

  // ------------------------------------------------ stage 3: output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_free) begin
      out_valid <= s2_move;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      left_out  <= mix_l;
      right_out <= mix_r;
    end
  end

  assign mixed.valid     = out_valid;
  assign mixed.left_out  = left_out;
  assign mixed.right_out = right_out;

endmodule

/* rtl/spfd_dline.sv */
// One circular delay memory: single write port, one read port with a
// registered, read-first output held while no read is enabled. Uses spfd_pkg.
module spfd_dline import spfd_pkg::*; #(
  parameter int DEPTH = MAX_DELAY_DEF,
  parameter int WIDTH = SAMPLE_BITS_DEF,
  localparam int ABITS = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [ABITS-1:0] raddr,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-cycle collision
  always_ff @(posedge clk) begin
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

/* tb/tb_stereo_pingpong_feedback_delay_top.sv */
// Self-checking testbench for the stereo ping-pong feedback delay top level.
// Depends on spfd_pkg, the spfd_if channel interfaces and the block's RTL.
// Stimulus: directed extremes, then randomized register settings and sample streams.

module tb_stereo_pingpong_feedback_delay_top;
  import spfd_pkg::*;

  localparam int SB    = SAMPLE_BITS_DEF;
  localparam int MAXD  = MAX_DELAY_DEF;
  localparam int LIMIT = 400000;
  localparam int MAX_PRINTS = 40;

  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  typedef struct packed {
    logic signed [SB-1:0] l;
    logic signed [SB-1:0] r;
  } pair_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;
  } reg_write_t;

  logic clk;
  logic rst;

  spfd_in_if  #(.SampleBits(SB)) samples_if ();
  spfd_out_if #(.SampleBits(SB)) mixed_if ();
  spfd_cfg_if                    cfg_if ();

  stereo_pingpong_feedback_delay_top #(
    .MAX_DELAY  (MAXD),
    .SAMPLE_BITS(SB)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(samples_if),
    .mixed  (mixed_if),
    .cfg    (cfg_if)
  );

  // Stimulus queues and expected output pairs
  pair_t      stim_q[$];
  reg_write_t reg_q[$];
  pair_t      expected_mix[$];

  int send_idle_pct = 28;
  int recv_idle_pct = 50;
  int mismatches = 0;
  int out_beats = 0;
  int cycles = 0;

  // Shadow of the register file and delay memories
  logic [15:0] dly_left  = 16'd1;
  logic [15:0] dly_right = 16'd1;
  logic [15:0] fb_gain   = 16'd0;
  logic [16:0] wet_reg   = 17'd0;
  logic        cross_fb  = 1'b0;
  bit signed [SB-1:0] left_mem  [MAXD];
  bit signed [SB-1:0] right_mem [MAXD];
  int unsigned wr_ptr = 0;

  // Clock, and known values on every input from time zero
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    samples_if.valid    = 1'b0;
    samples_if.left_in  = '0;
    samples_if.right_in = '0;
    mixed_if.ready      = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    forever #2 clk = ~clk;
  end

  // Divide by 2^16, round to nearest, ties away from zero
  function automatic longint div_q16_round(input longint v);
    if (v >= 0) return (v + RND_HALF) >>> Q16_SHIFT;
    return -((-v + RND_HALF) >>> Q16_SHIFT);
  endfunction

  function automatic logic signed [SB-1:0] clip_sample(input longint v);
    if (v > longint'(S_MAX)) return S_MAX;
    if (v < longint'(S_MIN)) return S_MIN;
    return v[SB-1:0];
  endfunction

  function automatic int unsigned tap_slot(input logic [15:0] dly);
    int unsigned d;
    d = (dly > MAXD - 1) ? MAXD - 1 : dly;
    return (wr_ptr + MAXD - d) % MAXD;
  endfunction

  // One sample pair through the delay lines: returns the mixed pair, updates memory
  function automatic pair_t advance_delay_lines(input pair_t x);
    longint in_l, in_r, dl, dr, src_l, src_r, wet, dry, fb;
    pair_t  res;
    in_l = x.l;
    in_r = x.r;
    dl = left_mem[tap_slot(dly_left)];
    dr = right_mem[tap_slot(dly_right)];
    src_l = cross_fb ? dr : dl;
    src_r = cross_fb ? dl : dr;
    fb = fb_gain;
    wet = (wet_reg > UNITY_Q16) ? UNITY_Q16 : wet_reg;
    dry = UNITY_Q16 - wet;
    res.l = clip_sample(div_q16_round(in_l * dry + dl * wet));
    res.r = clip_sample(div_q16_round(in_r * dry + dr * wet));
    left_mem[wr_ptr]  = clip_sample(in_l + div_q16_round(src_l * fb));
    right_mem[wr_ptr] = clip_sample(in_r + div_q16_round(src_r * fb));
    wr_ptr = (wr_ptr + 1) % MAXD;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [SB-1:0] got,
                               input logic [SB-1:0] want);
    if (mismatches < MAX_PRINTS)
      $display("%0t out beat %0d %s: got %h want %h", $time, out_beats, what, got, want);
    mismatches++;
  endtask

  // Sample driver: advances only when the current beat is taken or none is up
  always @(posedge clk) begin : sample_driver
    pair_t nxt;
    if (rst) begin
      samples_if.valid <= 1'b0;
    end else if (!samples_if.valid || samples_if.ready) begin
      if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = stim_q.pop_front();
        samples_if.valid    <= 1'b1;
        samples_if.left_in  <= nxt.l;
        samples_if.right_in <= nxt.r;
      end else begin
        samples_if.valid <= 1'b0;
      end
    end
  end

  // Register write driver, no idle gaps while writes are queued
  always @(posedge clk) begin : reg_driver
    reg_write_t w;
    if (rst) begin
      cfg_if.valid <= 1'b0;
    end else if (!cfg_if.valid || cfg_if.ready) begin
      if (reg_q.size() != 0) begin
        w = reg_q.pop_front();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= w.idx;
        cfg_if.data  <= w.data;
      end else begin
        cfg_if.valid <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(posedge clk) begin
    if (rst) mixed_if.ready <= 1'b0;
    else mixed_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: register writes, accepted pairs into the predictor, output check
  always @(posedge clk) begin : monitor
    pair_t want;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_DELAY_LEFT:    dly_left  = cfg_if.data[15:0];
          REG_DELAY_RIGHT:   dly_right = cfg_if.data[15:0];
          REG_FEEDBACK_GAIN: fb_gain   = cfg_if.data[15:0];
          REG_WET_MIX:       wet_reg   = cfg_if.data[16:0];
          REG_PING_PONG:     cross_fb  = cfg_if.data[0];
          default: ;
        endcase
      end
      if (samples_if.valid && samples_if.ready)
        expected_mix.push_back(advance_delay_lines({samples_if.left_in, samples_if.right_in}));
      if (mixed_if.valid && mixed_if.ready) begin
        if (expected_mix.size() == 0) begin
          flag_mismatch("unexpected beat", mixed_if.left_out, '0);
        end else begin
          want = expected_mix.pop_front();
          if (mixed_if.left_out !== want.l)
            flag_mismatch("left_out", mixed_if.left_out, want.l);
          if (mixed_if.right_out !== want.r)
            flag_mismatch("right_out", mixed_if.right_out, want.r);
        end
        out_beats++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("stereo_pingpong_feedback_delay_top: mismatch");
      $finish;
    end
  end

  task automatic queue_pair(input logic signed [SB-1:0] l, input logic signed [SB-1:0] r);
    stim_q.push_back({l, r});
  endtask

  // Wait until every pair went in and came out, then let the pipeline settle
  task automatic drain();
    do @(negedge clk);
    while (stim_q.size() != 0 || samples_if.valid || expected_mix.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // Full register update plus one write to an unused index
  task automatic set_regs(input logic [CFG_DATA_BITS-1:0] dl, input logic [CFG_DATA_BITS-1:0] dr,
                          input logic [CFG_DATA_BITS-1:0] fb, input logic [CFG_DATA_BITS-1:0] wet,
                          input logic [CFG_DATA_BITS-1:0] pp);
    reg_write_t junk;
    junk.idx  = CFG_IDX_BITS'($urandom_range(REG_PING_PONG + 1, (1 << CFG_IDX_BITS) - 1));
    junk.data = CFG_DATA_BITS'($urandom);
    reg_q.push_back(junk);
    reg_q.push_back({REG_DELAY_LEFT, dl});
    reg_q.push_back({REG_DELAY_RIGHT, dr});
    reg_q.push_back({REG_FEEDBACK_GAIN, fb});
    reg_q.push_back({REG_WET_MIX, wet});
    reg_q.push_back({REG_PING_PONG, pp});
    do @(negedge clk);
    while (reg_q.size() != 0 || cfg_if.valid);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_delay();
    logic [CFG_DATA_BITS-1:0] v;
    case ($urandom_range(11))
      0: v = 17'd0;
      1: v = 17'd1;
      2: v = 17'd2;
      3: v = 17'd3;
      4: v = 17'h0FFFF;
      5, 6: v = CFG_DATA_BITS'($urandom_range(4, 16));
      7, 8: v = CFG_DATA_BITS'($urandom_range(1, 64));
      9: v = CFG_DATA_BITS'($urandom_range(65, 600));
      default: v = CFG_DATA_BITS'($urandom_range(1, 8));
    endcase
    // bit 16 is dropped by the 16-bit register
    v[16] = 1'($urandom_range(1));
    return v;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_gain();
    case ($urandom_range(5))
      0: return 17'd0;
      1: return 17'h0FFFF;
      2: return 17'h08000;
      default: return CFG_DATA_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_wet();
    case ($urandom_range(6))
      0: return 17'd0;
      1: return CFG_DATA_BITS'(UNITY_Q16);
      2: return CFG_DATA_BITS'(RND_HALF);
      3: return CFG_DATA_BITS'($urandom_range(UNITY_Q16 + 1, (1 << CFG_DATA_BITS) - 1));
      default: return CFG_DATA_BITS'($urandom_range(0, UNITY_Q16));
    endcase
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    logic [SB-1:0] raw;
    raw = SB'($urandom);
    case ($urandom_range(9))
      0: return S_MAX;
      1: return S_MIN;
      2: return {{(SB-9){raw[8]}}, raw[8:0]};
      3: return S_MAX - raw[7:0];
      4: return S_MIN + raw[7:0];
      default: return raw;
    endcase
  endfunction

  // Main sequence
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: one-sample delay, no feedback, fully dry
    queue_pair(S_MAX, S_MIN);
    queue_pair(S_MIN, S_MAX);
    queue_pair(1, -1);
    queue_pair(0, 0);
    drain();

    // Short delays with crossed half-gain feedback and half mix; hits
    // feedback saturation and rounding ties
    set_regs(17'h10002, 17'd1, 17'h08000, 17'h08000, 17'h1FFFF);
    queue_pair(S_MAX, S_MAX);
    queue_pair(S_MAX, S_MAX);
    queue_pair(S_MIN, S_MIN);
    queue_pair(S_MIN, S_MIN);
    queue_pair(1, -1);
    queue_pair(0, 0);
    queue_pair(0, 0);
    queue_pair(-1, 1);
    queue_pair(0, 0);
    queue_pair(0, 0);
    drain();

    // Zero delay, longest delay, top gain, wet above unity
    set_regs(17'h10000, 17'h0FFFF, 17'h0FFFF, 17'h1FFFF, 17'h1FFFE);
    queue_pair(S_MAX, S_MIN);
    queue_pair(S_MIN, S_MAX);
    queue_pair(S_MAX, S_MAX);
    queue_pair(S_MIN, S_MIN);
    queue_pair(0, 0);
    queue_pair(1, 1);
    queue_pair(-1, -1);
    queue_pair(S_MAX, S_MIN);
    drain();

    // Random settings and sample streams
    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 28;
        recv_idle_pct = 50;
      end else if (ph < 7) begin
        send_idle_pct = 50;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_regs(pick_delay(), pick_delay(), pick_gain(), pick_wet(),
               CFG_DATA_BITS'($urandom_range(7)));
      for (int i = 0; i < 155; i++) queue_pair(pick_sample(), pick_sample());
      drain();
    end

    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("stereo_pingpong_feedback_delay_top: match");
    end else begin
      $display("stereo_pingpong_feedback_delay_top: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/spfd_pkg.sv
rtl/spfd_if.sv
rtl/spfd_dline.sv
rtl/stereo_pingpong_feedback_delay_top.sv
tb/tb_stereo_pingpong_feedback_delay_top.sv
